>>> rtl/core/csv_scalar_syntax_check_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CSV_SCALAR_SYNTAX_CHECK_CORE_DEFINES_SVH
`define CSV_SCALAR_SYNTAX_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CSV_SSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csv_ssc assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CSV_SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csv_ssc assertion failed");

`endif

>>> rtl/core/csv_ssc_pkg.sv
package csv_ssc_pkg;

  // column type codes
  localparam logic [2:0] TYPE_BOOL = 3'd1;
  localparam logic [2:0] TYPE_INT  = 3'd2;
  localparam logic [2:0] TYPE_DEC  = 3'd3;

  localparam logic [7:0] LOWER_MASK = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_UP_E    = 8'h45;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [2:0] TRUE_LEN  = 3'd4;
  localparam logic [2:0] FALSE_LEN = 3'd5;
  localparam logic [2:0] COUNT_MAX = 3'd7;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_MANT     = 3'd1,
    PH_EXP_MARK = 3'd2,
    PH_EXP_SIGN = 3'd3,
    PH_EXP_DIG  = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       digit_seen;
    logic       dot_seen;
    logic       failed;
    logic [2:0] bool_count;
    logic       match_true;
    logic       match_false;
  } st_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keep;
    logic       value_end;
    logic       valid_res;
  } res_t;

  localparam st_t ST_CLEAR = '{
    phase:       PH_START,
    digit_seen:  1'b0,
    dot_seen:    1'b0,
    failed:      1'b0,
    bool_count:  3'd0,
    match_true:  1'b1,
    match_false: 1'b1
  };

  function automatic logic [7:0] true_char(input logic [1:0] idx);
    case (idx)
      2'd0:    true_char = 8'h74; // t
      2'd1:    true_char = 8'h72; // r
      2'd2:    true_char = 8'h75; // u
      default: true_char = 8'h65; // e
    endcase
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] idx);
    case (idx)
      3'd1:    false_char = 8'h61; // a
      3'd2:    false_char = 8'h6c; // l
      3'd3:    false_char = 8'h73; // s
      3'd4:    false_char = 8'h65; // e
      default: false_char = 8'h66; // f
    endcase
  endfunction

endpackage

>>> rtl/core/csv_ssc_step.sv
module csv_ssc_step import csv_ssc_pkg::*; (
  input  st_t        state_i,
  input  logic [7:0] data_byte_i,
  input  logic [2:0] value_type_i,
  input  logic       last_byte_i,
  input  logic       empty_value_i,
  output st_t        state_o,
  output res_t       res_o
);

  logic       is_dec;
  logic       is_digit;
  logic       is_sign;
  logic       is_exp;
  logic [7:0] low;
  st_t        upd;
  logic       verdict;

  always_comb begin
    is_dec   = (value_type_i == TYPE_DEC);
    is_digit = data_byte_i inside {[CH_ZERO:CH_NINE]};
    is_sign  = data_byte_i inside {CH_PLUS, CH_MINUS};
    is_exp   = data_byte_i inside {CH_LOW_E, CH_UP_E};
    low      = data_byte_i | LOWER_MASK;
    upd      = state_i;

    if (!(is_dec && data_byte_i == CH_COMMA)) begin
      // numeric recognizer
      if (!state_i.failed) begin
        if (state_i.phase == PH_START) begin
          upd.phase = PH_MANT;
        end
        if (!(state_i.phase == PH_START && is_sign)) begin
          case (upd.phase)
            PH_MANT: begin
              if (is_digit) begin
                upd.digit_seen = 1'b1;
              end else if (is_dec && data_byte_i == CH_DOT && !state_i.dot_seen) begin
                upd.dot_seen = 1'b1;
              end else if (is_dec && is_exp && state_i.digit_seen) begin
                upd.phase = PH_EXP_MARK;
              end else begin
                upd.failed = 1'b1;
              end
            end
            PH_EXP_MARK: begin
              if (is_sign) begin
                upd.phase = PH_EXP_SIGN;
              end else if (is_digit) begin
                upd.phase = PH_EXP_DIG;
              end else begin
                upd.failed = 1'b1;
              end
            end
            PH_EXP_SIGN, PH_EXP_DIG: begin
              if (is_digit) begin
                upd.phase = PH_EXP_DIG;
              end else begin
                upd.failed = 1'b1;
              end
            end
            default: upd.failed = 1'b1;
          endcase
        end
      end
      // boolean recognizer
      if (state_i.bool_count >= TRUE_LEN || low != true_char(state_i.bool_count[1:0])) begin
        upd.match_true = 1'b0;
      end
      if (state_i.bool_count >= FALSE_LEN || low != false_char(state_i.bool_count)) begin
        upd.match_false = 1'b0;
      end
      if (state_i.bool_count != COUNT_MAX) begin
        upd.bool_count = state_i.bool_count + 3'd1;
      end
    end

    case (value_type_i)
      TYPE_BOOL: verdict = (upd.match_true && upd.bool_count == TRUE_LEN) ||
                           (upd.match_false && upd.bool_count == FALSE_LEN);
      TYPE_INT, TYPE_DEC: begin
        if (upd.failed) begin
          verdict = 1'b0;
        end else if (upd.phase == PH_START || upd.phase == PH_MANT) begin
          verdict = upd.digit_seen;
        end else begin
          verdict = (upd.phase == PH_EXP_DIG);
        end
      end
      default: verdict = 1'b1;
    endcase

    if (empty_value_i) begin
      state_o         = ST_CLEAR;
      res_o.out_byte  = 8'h00;
      res_o.keep      = 1'b0;
      res_o.value_end = 1'b1;
      res_o.valid_res = !(value_type_i inside {TYPE_BOOL, TYPE_INT, TYPE_DEC});
    end else begin
      state_o         = last_byte_i ? ST_CLEAR : upd;
      res_o.out_byte  = data_byte_i;
      res_o.keep      = !(is_dec && data_byte_i == CH_COMMA);
      res_o.value_end = last_byte_i;
      res_o.valid_res = last_byte_i && verdict;
    end
  end

endmodule

>>> rtl/core/csv_scalar_syntax_check_core.sv
// CSV scalar syntax checker. Takes one byte of a field value per
// transaction and returns exactly one result transaction per input, in the
// cycle after acceptance: the byte (commas of decimal values flagged with
// keep low), a value_end flag, and on the closing result the verdict for
// the whole value under the type given on that item. Throughput is one
// byte per clock unless the consumer stalls; the only loop is the small
// recognizer state register, updated in the same cycle an item is accepted. in_ready_o is high while
// the result register is empty or being drained by out_ready_i, so a
// stalled consumer stalls the producer with no bubble on release.
module csv_scalar_syntax_check_core import csv_ssc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic [2:0] value_type_i,
  input  logic       last_byte_i,
  input  logic       empty_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       keep_o,
  output logic       value_end_o,
  output logic       valid_res_o
);

  st_t  state_q, state_d;
  res_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;

  // recognizer: current state plus incoming byte -> next state and result
  csv_ssc_step u_step (
    .state_i       (state_q),
    .data_byte_i   (data_byte_i),
    .value_type_i  (value_type_i),
    .last_byte_i   (last_byte_i),
    .empty_value_i (empty_value_i),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  // result register may refill in the cycle it drains
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state: recognizer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        state_q <= state_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = res_q.out_byte;
  assign keep_o      = res_q.keep;
  assign value_end_o = res_q.value_end;
  assign valid_res_o = res_q.valid_res;

endmodule

>>> rtl/core/csv_ssc_checker.sv
`include "csv_scalar_syntax_check_core_defines.svh"

module csv_ssc_checker import csv_ssc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       keep_o,
  input logic       value_end_o,
  input logic       valid_res_o
);

  // stalled result holds
  `CSV_SSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `CSV_SSC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                       $stable(out_byte_o) && $stable(keep_o) && $stable(value_end_o))
  // every accepted byte yields a result next cycle
  `CSV_SSC_ASSERT_NEXT(a_acc_result, in_valid_i && in_ready_o, out_valid_o)
  // verdict only on closing result
  `CSV_SSC_ASSERT_IMPL(a_verdict_end, out_valid_o && !value_end_o, !valid_res_o)
  // dropped bytes are decimal commas or empty-value markers
  `CSV_SSC_ASSERT_IMPL(a_drop_kind, out_valid_o && !keep_o,
                       out_byte_o == CH_COMMA || (out_byte_o == 8'h00 && value_end_o))

endmodule

bind csv_scalar_syntax_check_core csv_ssc_checker u_csv_ssc_checker (.*);
